### rtl/nvs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nvs_pkg
// Shared types, widths, defaults and the LFSR step for the NRU victim select.
// ----------------------------------------------------------------------------
package nvs_pkg;

    // field widths of the command and result words
    localparam int FUNC_W   = 1;
    localparam int FRAME_W  = 4;
    localparam int VADDR_W  = 12;
    localparam int PID_W    = 8;
    localparam int VPAGE_W  = 4;
    localparam int CLASS_W  = 2;
    localparam int PADDR_W  = 12;
    localparam int LFSR_W   = 16;

    // default sizing
    localparam int FRAMES_DEF     = 16;
    localparam int PAGE_BYTES_DEF = 256;

    // random source
    localparam logic [LFSR_W-1:0] SEED_RESET = 16'd44257;
    localparam logic [LFSR_W-1:0] LFSR_MASK  = 16'hB400;
    localparam logic [LFSR_W-1:0] SEED_ZERO  = 16'hACE1;

    // command codes
    localparam logic [FUNC_W-1:0] FUNC_ACCESS  = 1'b0;
    localparam logic [FUNC_W-1:0] FUNC_REPLACE = 1'b1;

    // one frame table entry
    typedef struct packed {
        logic               ref_bit;
        logic               mod_bit;
        logic [PID_W-1:0]   owner;
        logic [VPAGE_W-1:0] vpage;
    } t_frame_ent;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ACC_RD,
        S_ACC_WR,
        S_CNT,
        S_CLS,
        S_REM,
        S_SCAN,
        S_OUT
    } t_state;

    // Galois step: shift right, fold mask in when the low bit falls out
    function automatic logic [LFSR_W-1:0] lfsr_next(input logic [LFSR_W-1:0] s);
        logic [LFSR_W-1:0] t;
        t = s >> 1;
        if (s[0]) begin
            t = t ^ LFSR_MASK;
        end
        return t;
    endfunction

    // a zero seed would lock the LFSR
    function automatic logic [LFSR_W-1:0] seed_load(input logic [LFSR_W-1:0] seed);
        return (seed != '0) ? seed : SEED_ZERO;
    endfunction

endpackage
`default_nettype wire

### rtl/nvs_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nvs_ram
// Single write port, single read port RAM with a registered read.
// ----------------------------------------------------------------------------
module nvs_ram #(
    parameter int DEPTH = 16,
    parameter int DW    = 14
) (
    input  wire logic                                      i_clk,
    input  wire logic                                      i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [DW-1:0]                             i_wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [DW-1:0]                             o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, registered
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

### rtl/nvs_rem.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nvs_rem
// Restoring remainder unit: 16-bit dividend mod a narrow divisor, one
// dividend bit per cycle.
// ----------------------------------------------------------------------------
module nvs_rem #(
    parameter int CW = 5
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_start,
    input  wire logic [nvs_pkg::LFSR_W-1:0] i_dividend,
    input  wire logic [CW-1:0]             i_divisor,
    output logic                           o_done,
    output logic      [CW-1:0]             o_rem
);
    import nvs_pkg::*;

    localparam int SW = $clog2(LFSR_W + 1);

    logic              r_busy;
    logic              r_done;
    logic [SW-1:0]     r_step;
    logic [LFSR_W-1:0] r_dvd;
    logic [CW-1:0]     r_div;
    logic [CW-1:0]     r_rem;
    logic [CW:0]       trial;
    logic [CW:0]       diff;

    // shift next dividend bit in, subtract if it fits
    assign trial = {r_rem, r_dvd[LFSR_W-1]};
    assign diff  = trial - {1'b0, r_div};

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_step == SW'(1))) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_step <= SW'(LFSR_W);
            r_dvd  <= i_dividend;
            r_div  <= i_divisor;
            r_rem  <= '0;
        end else if (r_busy) begin
            r_step <= r_step - SW'(1);
            r_dvd  <= r_dvd << 1;
            if (trial >= {1'b0, r_div}) begin
                r_rem <= diff[CW-1:0];
            end else begin
                r_rem <= trial[CW-1:0];
            end
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule
`default_nettype wire

### rtl/nru_page_victim_select.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nru_page_victim_select
// Not-recently-used page replacement over a frame table held in one RAM.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: a word is taken when i_start is high and o_busy is low.
//   i_func selects an access (marks referenced, and modified on a write) or
//   a replace (page fault). An access gives no result and holds o_busy
//   while it reads and writes its entry; an access to a frame beyond the
//   table is dropped at once. A replace counts the four NRU classes through
//   the RAM read port, picks the class, runs the serial remainder unit
//   (LFSR mod class size), scans for the chosen member, and writes the
//   frame back. The result word shows on the o_ result ports with o_valid
//   for exactly one cycle, the cycle in which o_busy falls; the
//   receiver cannot stall it, and a new command may be taken in that cycle.
//   Config channel: a write of i_cfg_data (LFSR seed) is taken when
//   i_cfg_valid is high; o_cfg_ready is always high. Write only when idle.
//   Reset: table reads as all zero (per-frame valid flags), LFSR = 44257.
// ----------------------------------------------------------------------------
module nru_page_victim_select #(
    parameter int FRAMES     = nvs_pkg::FRAMES_DEF,
    parameter int PAGE_BYTES = nvs_pkg::PAGE_BYTES_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    // command channel
    input  wire logic                        i_start,
    output logic                             o_busy,
    input  wire logic [nvs_pkg::FUNC_W-1:0]  i_func,
    input  wire logic [nvs_pkg::FRAME_W-1:0] i_frame,
    input  wire logic                        i_is_write,
    input  wire logic [nvs_pkg::VADDR_W-1:0] i_virt_addr,
    input  wire logic [nvs_pkg::PID_W-1:0]   i_process_id,
    // config channel
    input  wire logic                        i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire logic [nvs_pkg::LFSR_W-1:0]  i_cfg_data,
    // result channel
    output logic                             o_valid,
    output logic      [nvs_pkg::FRAME_W-1:0] o_victim_frame,
    output logic      [nvs_pkg::CLASS_W-1:0] o_victim_class,
    output logic                             o_writeback,
    output logic      [nvs_pkg::PID_W-1:0]   o_evicted_pid,
    output logic      [nvs_pkg::VPAGE_W-1:0] o_evicted_vpage,
    output logic      [nvs_pkg::PADDR_W-1:0] o_phys_addr
);
    import nvs_pkg::*;

    localparam int AW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int CW = $clog2(FRAMES + 1);
    // PAGE_BYTES is a power of two: offset and page number are bit fields
    localparam int PB = $clog2(PAGE_BYTES);
    localparam int EW = $bits(t_frame_ent);

    t_state              r_state, n_state;
    logic [FRAMES-1:0]   r_vld;
    logic [LFSR_W-1:0]   r_lfsr;
    logic                r_valid;
    logic                r_rd_live;
    logic [AW-1:0]       r_rd_addr;
    logic [AW:0]         r_addr;
    logic [CW-1:0]       r_cnt [4];
    logic [CLASS_W-1:0]  r_cls;
    logic [CW-1:0]       r_pick;
    logic [CW-1:0]       r_seen;
    logic                r_found;
    logic [AW-1:0]       r_vic_idx;
    t_frame_ent          r_vic_word;
    logic [AW-1:0]       r_frame;
    logic                r_is_write;
    logic [VADDR_W-1:0]  r_vaddr;
    logic [PID_W-1:0]    r_pid;

    logic [FRAME_W-1:0]  r_victim_frame;
    logic [CLASS_W-1:0]  r_victim_class;
    logic                r_writeback;
    logic [PID_W-1:0]    r_evicted_pid;
    logic [VPAGE_W-1:0]  r_evicted_vpage;
    logic [PADDR_W-1:0]  r_phys_addr;

    logic                start_ok;
    logic                frame_ok;
    logic                cfg_we;
    logic                issue;
    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [AW-1:0]       ram_raddr;
    t_frame_ent          ram_wdata;
    logic [EW-1:0]       ram_q;
    t_frame_ent          rd_word;
    logic [CLASS_W-1:0]  word_cls;
    logic [CLASS_W-1:0]  cls_sel;
    logic                rem_start;
    logic                rem_done;
    logic [CW-1:0]       rem_val;

    // handshakes
    assign start_ok    = i_start && (r_state == S_IDLE);
    assign o_busy      = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid;
    assign frame_ok    = (32'(i_frame) < 32'(FRAMES));

    // frame table storage
    nvs_ram #(
        .DEPTH (FRAMES),
        .DW    (EW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_q)
    );

    // entries never written read as zero
    assign rd_word  = r_vld[r_rd_addr] ? t_frame_ent'(ram_q) : '0;
    assign word_cls = {rd_word.ref_bit, rd_word.mod_bit};

    // lowest non-empty class
    always_comb begin
        if (r_cnt[0] != '0) begin
            cls_sel = 2'd0;
        end else if (r_cnt[1] != '0) begin
            cls_sel = 2'd1;
        end else if (r_cnt[2] != '0) begin
            cls_sel = 2'd2;
        end else begin
            cls_sel = 2'd3;
        end
    end

    // serial remainder: LFSR mod class size
    nvs_rem #(
        .CW (CW)
    ) u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (rem_start),
        .i_dividend (r_lfsr),
        .i_divisor  (r_cnt[cls_sel]),
        .o_done     (rem_done),
        .o_rem      (rem_val)
    );

    // next state and RAM control
    always_comb begin
        n_state   = r_state;
        ram_we    = 1'b0;
        ram_waddr = r_frame;
        ram_wdata = rd_word;
        ram_raddr = '0;
        issue     = 1'b0;
        rem_start = 1'b0;
        unique case (r_state) inside
            S_IDLE: begin
                if (i_start) begin
                    if (i_func == FUNC_REPLACE) begin
                        n_state = S_CNT;
                    end else if (frame_ok) begin
                        n_state = S_ACC_RD;
                    end
                end
            end
            S_ACC_RD: begin
                ram_raddr = r_frame;
                n_state   = S_ACC_WR;
            end
            S_ACC_WR: begin
                ram_we            = 1'b1;
                ram_wdata.ref_bit = 1'b1;
                ram_wdata.mod_bit = rd_word.mod_bit | r_is_write;
                n_state           = S_IDLE;
            end
            S_CNT, S_SCAN: begin
                issue = (r_addr < (AW+1)'(FRAMES));
                if (issue) begin
                    ram_raddr = r_addr[AW-1:0];
                end
                if (!issue && !r_rd_live) begin
                    n_state = (r_state == S_CNT) ? S_CLS : S_OUT;
                end
            end
            S_CLS: begin
                rem_start = 1'b1;
                n_state   = S_REM;
            end
            S_REM: begin
                if (rem_done) begin
                    n_state = S_SCAN;
                end
            end
            S_OUT: begin
                ram_we            = 1'b1;
                ram_waddr         = r_vic_idx;
                ram_wdata.ref_bit = 1'b0;
                ram_wdata.mod_bit = 1'b0;
                ram_wdata.owner   = r_pid;
                ram_wdata.vpage   = VPAGE_W'(r_vaddr >> PB);
                n_state           = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_vld     <= '0;
            r_lfsr    <= SEED_RESET;
            r_valid   <= 1'b0;
            r_rd_live <= 1'b0;
            r_found   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_valid   <= (r_state == S_OUT);
            r_rd_live <= issue;
            if (ram_we) begin
                r_vld[ram_waddr] <= 1'b1;
            end
            if (cfg_we) begin
                r_lfsr <= seed_load(i_cfg_data);
            end else if (start_ok && (i_func == FUNC_REPLACE)) begin
                r_lfsr <= lfsr_next(r_lfsr);
            end
            if (rem_done) begin
                r_found <= 1'b0;
            end else if ((r_state == S_SCAN) && r_rd_live && (word_cls == r_cls)
                         && (r_seen == r_pick)) begin
                r_found <= 1'b1;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_rd_addr <= ram_raddr;

        // latch the command word
        if (start_ok) begin
            r_frame    <= AW'(i_frame);
            r_is_write <= i_is_write;
            r_vaddr    <= i_virt_addr;
            r_pid      <= i_process_id;
            r_addr     <= '0;
            for (int c = 0; c < 4; c++) begin
                r_cnt[c] <= '0;
            end
        end

        if (issue) begin
            r_addr <= r_addr + (AW+1)'(1);
        end

        // class census
        if ((r_state == S_CNT) && r_rd_live) begin
            r_cnt[word_cls] <= r_cnt[word_cls] + CW'(1);
        end

        if (r_state == S_CLS) begin
            r_cls <= cls_sel;
        end

        // start of the member scan
        if (rem_done) begin
            r_pick <= rem_val;
            r_addr <= '0;
            r_seen <= '0;
        end

        // pick-th member of the class, ascending frame order
        if ((r_state == S_SCAN) && r_rd_live && (word_cls == r_cls) && !r_found) begin
            if (r_seen == r_pick) begin
                r_vic_idx  <= r_rd_addr;
                r_vic_word <= rd_word;
            end else begin
                r_seen <= r_seen + CW'(1);
            end
        end

        // result word
        if (r_state == S_OUT) begin
            r_victim_frame  <= FRAME_W'(r_vic_idx);
            r_victim_class  <= r_cls;
            r_writeback     <= r_vic_word.mod_bit;
            r_evicted_pid   <= r_vic_word.owner;
            r_evicted_vpage <= r_vic_word.vpage;
            r_phys_addr     <= PADDR_W'({r_vic_idx, r_vaddr[PB-1:0]});
        end
    end

    assign o_valid         = r_valid;
    assign o_victim_frame  = r_victim_frame;
    assign o_victim_class  = r_victim_class;
    assign o_writeback     = r_writeback;
    assign o_evicted_pid   = r_evicted_pid;
    assign o_evicted_vpage = r_evicted_vpage;
    assign o_phys_addr     = r_phys_addr;

    // checks
    a_valid_after_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(r_state == S_OUT))
        else $error("result strobe without a write-back cycle");

    a_ram_we_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> ((r_state == S_ACC_WR) || (r_state == S_OUT)))
        else $error("table write outside an update cycle");

    a_victim_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT) |-> r_found)
        else $error("scan ended without a victim");

    a_census_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLS) |-> ((32'(r_cnt[0]) + 32'(r_cnt[1]) + 32'(r_cnt[2])
                                 + 32'(r_cnt[3])) == 32'(FRAMES)))
        else $error("class census does not cover every frame");

    a_lfsr_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lfsr != '0)
        else $error("LFSR locked at zero");

endmodule
`default_nettype wire
